>>> rtl/sem_pkg.sv
// Shared constants, types and helper functions of the Sobel edge magnitude block.
package sem_pkg;

	localparam int MAX_WIDTH    = 2048;
	localparam int MAX_HEIGHT   = 4096;
	localparam int MIN_SIZE     = 3;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(MAX_HEIGHT);
	localparam int PIX_W        = 8;
	localparam int WIDTH_REG_W  = 12;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_W        = 13;
	localparam int GRAD_W       = 10;
	localparam int SQ_W         = 2 * GRAD_W;
	localparam int ENERGY_W     = SQ_W + 1;
	localparam int ROOT_W       = 16;
	localparam int ROOT_STEPS   = ROOT_W / 2;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	localparam logic [PIX_W-1:0]  MAG_MAX    = '1;
	localparam logic [ROOT_W-1:0] ROOT_FIRST = ROOT_W'(1) << (ROOT_W - 2);

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// Data handed from one square root cell to the next.
	typedef struct packed {
		logic              last;
		logic              sat;
		logic [ROOT_W-1:0] op;
		logic [ROOT_W-1:0] res;
		logic [ROOT_W-1:0] one;
	} root_data_t;

	typedef struct packed {
		logic       valid;
		root_data_t data;
	} root_t;

	// Last column index in use for a programmed width.
	function automatic logic [COL_W-1:0] last_col_of(logic [WIDTH_REG_W-1:0] w);
		int v;
		v = int'(w);
		if (v < MIN_SIZE) v = MIN_SIZE;
		if (v > MAX_WIDTH) v = MAX_WIDTH;
		return COL_W'(v - 1);
	endfunction

	// Last row index in use for a programmed height.
	function automatic logic [ROW_W-1:0] last_row_of(logic [HEIGHT_REG_W-1:0] h);
		int v;
		v = int'(h);
		if (v < MIN_SIZE) v = MIN_SIZE;
		if (v > MAX_HEIGHT) v = MAX_HEIGHT;
		return ROW_W'(v - 1);
	endfunction

endpackage

>>> rtl/sem_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module sem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/sem_front.sv
// Raster counters, line stores, 3x3 window, gradient sums and gradient energy.
module sem_front
	import sem_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             accept,
	input  logic [PIX_W-1:0] pixel_value,
	input  logic [COL_W-1:0] last_col,
	input  logic [ROW_W-1:0] last_row,
	output root_t            root_s5
);

	logic [COL_W-1:0] column_count_q;
	logic [ROW_W-1:0] row_count_q;
	logic [COL_W-1:0] col;
	logic [ROW_W-1:0] row;
	logic             end_row;
	logic             end_frame;
	logic             interior;

	logic             valid_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic [COL_W-1:0] col_s1;
	logic             interior_s1;
	logic             last_s1;

	logic [PIX_W-1:0] top_rd;
	logic [PIX_W-1:0] mid_rd;
	logic             shift;

	logic [PIX_W-1:0] win_q [3][3];

	logic              valid_s2;
	logic              last_s2;
	logic [GRAD_W-1:0] gx_pos;
	logic [GRAD_W-1:0] gx_neg;
	logic [GRAD_W-1:0] gy_pos;
	logic [GRAD_W-1:0] gy_neg;

	logic              valid_s3;
	logic              last_s3;
	logic [GRAD_W-1:0] ax_s3;
	logic [GRAD_W-1:0] ay_s3;

	logic            valid_s4;
	logic            last_s4;
	logic [SQ_W-1:0] sqx_s4;
	logic [SQ_W-1:0] sqy_s4;

	logic [ENERGY_W-1:0] energy;

	logic       valid_s5;
	root_data_t data_s5;

	// A counter at or past the last index in use ends its row or frame.
	always_comb begin
		end_row   = (column_count_q >= last_col);
		col       = end_row ? last_col : column_count_q;
		row       = (row_count_q >= last_row) ? last_row : row_count_q;
		end_frame = end_row && (row == last_row);
		interior  = (col >= COL_W'(2)) && (row >= ROW_W'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (accept) begin
			if (end_frame) begin
				column_count_q <= '0;
				row_count_q    <= '0;
			end else if (end_row) begin
				column_count_q <= '0;
				row_count_q    <= row + ROW_W'(1);
			end else begin
				column_count_q <= col + COL_W'(1);
				row_count_q    <= row;
			end
		end
	end

	// Stage 1: the line stores are read at the pixel's column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1    <= pixel_value;
			col_s1      <= col;
			interior_s1 <= interior;
			last_s1     <= end_frame;
		end
	end

	assign shift = adv && valid_s1;

	sem_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_upper_line (
		.clk   (clk),
		.we    (shift),
		.waddr (col_s1),
		.wdata (mid_rd),
		.re    (accept),
		.raddr (col),
		.rdata (top_rd)
	);

	sem_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_middle_line (
		.clk   (clk),
		.we    (shift),
		.waddr (col_s1),
		.wdata (pixel_s1),
		.re    (accept),
		.raddr (col),
		.rdata (mid_rd)
	);

	// Stage 2: the window takes the new column; rows run top to bottom.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				for (int l = 0; l < 3; l++) begin
					win_q[k][l] <= '0;
				end
			end
		end else if (shift) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= top_rd;
			win_q[1][2] <= mid_rd;
			win_q[2][2] <= pixel_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && interior_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// The window holds this item's pixels until the item leaves stage 2.
	always_comb begin
		gx_pos = GRAD_W'(win_q[0][0]) + (GRAD_W'(win_q[1][0]) << 1) + GRAD_W'(win_q[2][0]);
		gx_neg = GRAD_W'(win_q[0][2]) + (GRAD_W'(win_q[1][2]) << 1) + GRAD_W'(win_q[2][2]);
		gy_pos = GRAD_W'(win_q[0][0]) + (GRAD_W'(win_q[0][1]) << 1) + GRAD_W'(win_q[0][2]);
		gy_neg = GRAD_W'(win_q[2][0]) + (GRAD_W'(win_q[2][1]) << 1) + GRAD_W'(win_q[2][2]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			ax_s3   <= (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
			ay_s3   <= (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
			last_s4 <= last_s3;
			sqx_s4  <= SQ_W'(ax_s3) * SQ_W'(ax_s3);
			sqy_s4  <= SQ_W'(ay_s3) * SQ_W'(ay_s3);
		end
	end

	assign energy = {1'b0, sqx_s4} + {1'b0, sqy_s4};

	// Stage 5: energy enters the root chain; anything past 16 bits saturates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s5.last <= last_s4;
			data_s5.sat  <= (energy[ENERGY_W-1:ROOT_W] != '0);
			data_s5.op   <= energy[ROOT_W-1:0];
			data_s5.res  <= '0;
			data_s5.one  <= ROOT_FIRST;
		end
	end

	assign root_s5.valid = valid_s5;
	assign root_s5.data  = data_s5;

endmodule

>>> rtl/sem_root_cell.sv
// One step of the digit-by-digit square root, registered toward the next cell.
module sem_root_cell
	import sem_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  root_t cell_in,
	output root_t cell_out
);

	logic              valid_q;
	root_data_t        data_q;
	root_data_t        data_n;
	logic [ROOT_W:0]   trial;
	logic              take;

	always_comb begin
		trial  = {1'b0, cell_in.data.res} + {1'b0, cell_in.data.one};
		take   = ({1'b0, cell_in.data.op} >= trial);
		data_n = cell_in.data;
		if (take) begin
			data_n.op  = cell_in.data.op - trial[ROOT_W-1:0];
			data_n.res = (cell_in.data.res >> 1) + cell_in.data.one;
		end else begin
			data_n.res = cell_in.data.res >> 1;
		end
		data_n.one = cell_in.data.one >> 2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= cell_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= data_n;
		end
	end

	assign cell_out.valid = valid_q;
	assign cell_out.data  = data_q;

endmodule

>>> rtl/sobel_edge_magnitude.sv
// Top level of the Sobel 3x3 gradient magnitude block.
//
// Pixels enter in raster order on the pixel channel (pixel_valid, pixel_stall,
// pixel_value); a transfer happens at a rising edge with pixel_valid high and
// pixel_stall low. One result leaves on the edge channel for every interior
// pixel, that is every pixel at column 2 or beyond and row 2 or beyond; its
// window is centered one row up and one column left. last_of_frame marks the
// result given for the last pixel of the frame. Border pixels cause no result.
// The whole datapath is one pipeline that moves on every cycle unless a result
// sits in the output register and the receiver stalls it, so one pixel can be
// taken per cycle. The pipeline steps are one line store read, the window
// shift, the gradient sums, the squares, the energy sum, eight square root
// cells and the output register. While the receiver stalls a waiting result,
// pixel_stall is high and nothing inside moves. Reset clears the counters, the
// window and all valid bits, and sets the frame size back to 640 by 480. The
// line stores are not cleared; no result uses an entry before it is written.
// The user writes the size registers through cfg_write, cfg_index and cfg_data
// only while the block is idle; the block itself does not enforce this.
module sobel_edge_magnitude
	import sem_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  cfg_reg_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             pixel_valid,
	output logic             pixel_stall,
	input  logic [PIX_W-1:0] pixel_value,
	output logic             edge_valid,
	input  logic             edge_stall,
	output logic [PIX_W-1:0] edge_magnitude,
	output logic             last_of_frame
);

	logic             adv;
	logic             accept;
	logic [COL_W-1:0] last_col_q;
	logic [ROW_W-1:0] last_row_q;
	root_t            chain [ROOT_STEPS+1];

	logic             edge_valid_q;
	logic [PIX_W-1:0] edge_magnitude_q;
	logic             last_of_frame_q;

	// The size registers are kept as the last column and row indexes in use.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= COL_W'(RESET_WIDTH - 1);
			last_row_q <= ROW_W'(RESET_HEIGHT - 1);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					last_col_q <= last_col_of(cfg_data[WIDTH_REG_W-1:0]);
				end
				REG_IMAGE_HEIGHT: begin
					last_row_q <= last_row_of(cfg_data[HEIGHT_REG_W-1:0]);
				end
				default: begin
					last_col_q <= last_col_q;
				end
			endcase
		end
	end

	// The pipeline moves whenever the output register is empty or being taken.
	assign adv         = !edge_valid_q || !edge_stall;
	assign pixel_stall = !adv;
	assign accept      = pixel_valid && adv;

	sem_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.accept      (accept),
		.pixel_value (pixel_value),
		.last_col    (last_col_q),
		.last_row    (last_row_q),
		.root_s5     (chain[0])
	);

	// Each cell settles one bit of the root and hands its state on.
	for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
		sem_root_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.cell_in  (chain[i]),
			.cell_out (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_valid_q <= 1'b0;
		end else if (adv) begin
			edge_valid_q <= chain[ROOT_STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			edge_magnitude_q <= chain[ROOT_STEPS].data.sat ? MAG_MAX :
				chain[ROOT_STEPS].data.res[PIX_W-1:0];
			last_of_frame_q  <= chain[ROOT_STEPS].data.last;
		end
	end

	assign edge_valid     = edge_valid_q;
	assign edge_magnitude = edge_magnitude_q;
	assign last_of_frame  = last_of_frame_q;

endmodule
